// ===== src/cfmr_pkg.sv =====
// Package for the CRC framed message receiver: result type, status and kind
// codes, frame constants and the byte-wide CRC-16/ARC update function.
// Depends on nothing; every other file of the block imports it.
package cfmr_pkg;

   localparam int unsigned LEN_WIDTH  = 17;
   localparam int unsigned CRC_WIDTH  = 16;
   localparam int unsigned HEAD_BYTES = 8;

   localparam logic [CRC_WIDTH-1:0] CRC_POLY = 16'hA001;
   localparam logic [CRC_WIDTH-1:0] CRC_INIT = 16'h0000;
   localparam logic [31:0]          SYNC_WORD = 32'hBBACCAAA;
   localparam logic [LEN_WIDTH-1:0] MIN_PAYLOAD_LEN = 17'd4;
   localparam logic [LEN_WIDTH-1:0] MAX_LEN_RESET   = 17'd4096;

   localparam logic KIND_BODY   = 1'b0;
   localparam logic KIND_STATUS = 1'b1;

   localparam logic [1:0] STATUS_OK      = 2'd0;
   localparam logic [1:0] STATUS_BAD_SYNC = 2'd1;
   localparam logic [1:0] STATUS_BAD_LEN  = 2'd2;
   localparam logic [1:0] STATUS_BAD_CRC  = 2'd3;

   typedef struct packed {
      logic       kind;
      logic [7:0] body_byte;
      logic [7:0] frame_flags;
      logic [7:0] command;
      logic [1:0] status;
   } result_type;

   // Sync word byte expected at head position pos, little-endian order.
   function automatic logic [7:0] sync_byte(input logic [1:0] pos);
      logic [7:0] value;
      case (pos)
         2'd0:    value = SYNC_WORD[7:0];
         2'd1:    value = SYNC_WORD[15:8];
         2'd2:    value = SYNC_WORD[23:16];
         default: value = SYNC_WORD[31:24];
      endcase
      return value;
   endfunction

   // Reflected CRC-16 update with one data byte, eight bit steps.
   function automatic logic [CRC_WIDTH-1:0] crc_update(input logic [CRC_WIDTH-1:0] crc,
                                                       input logic [7:0] data);
      logic [CRC_WIDTH-1:0] value;
      value = crc ^ {8'h00, data};
      for (int k = 0; k < 8; k++) begin
         if (value[0]) begin
            value = (value >> 1) ^ CRC_POLY;
         end else begin
            value = value >> 1;
         end
      end
      return value;
   endfunction

endpackage

// ===== src/cfmr_parser.sv =====
// Input register and frame parser of the CRC framed message receiver.
// Holds the frame state and turns one byte into at most one result per cycle.
// Depends on cfmr_pkg.
module cfmr_parser (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic [7:0]                    req_rx_byte,
   input  logic [cfmr_pkg::LEN_WIDTH-1:0] max_len,
   input  logic                          res_space,
   output logic                          res_valid,
   output cfmr_pkg::result_type          res
);
   import cfmr_pkg::*;

   localparam logic PHASE_HEAD    = 1'b0;
   localparam logic PHASE_PAYLOAD = 1'b1;

   logic                 in_valid_ff, in_valid_in;
   logic [7:0]           in_byte_ff;
   logic                 phase_ff, phase_in;
   logic [LEN_WIDTH-1:0] count_ff, count_in;
   logic [LEN_WIDTH-1:0] len_ff, len_in;
   logic [CRC_WIDTH-1:0] crc_ff, crc_in;
   logic                 sync_bad_ff, sync_bad_in;
   logic                 len_high_ff, len_high_in;
   logic [7:0]           flags_ff, flags_in;
   logic [7:0]           command_ff, command_in;
   logic [7:0]           crc_low_ff, crc_low_in;
   logic                 fire;
   logic                 accept;
   logic [CRC_WIDTH-1:0] crc_next;
   logic [LEN_WIDTH:0]   idx_plus2;
   logic [LEN_WIDTH:0]   len_wide;

   assign fire      = in_valid_ff && res_space;
   assign req_stall = in_valid_ff && !res_space;
   assign accept    = req_valid && !req_stall;
   assign crc_next  = crc_update(crc_ff, in_byte_ff);
   assign idx_plus2 = {1'b0, count_ff} + (LEN_WIDTH+1)'(2);
   assign len_wide  = {1'b0, len_ff};

   always_comb begin
      if (accept) begin
         in_valid_in = 1'b1;
      end else if (fire) begin
         in_valid_in = 1'b0;
      end else begin
         in_valid_in = in_valid_ff;
      end
   end

   always_comb begin
      phase_in    = phase_ff;
      count_in    = count_ff;
      len_in      = len_ff;
      crc_in      = crc_ff;
      sync_bad_in = sync_bad_ff;
      len_high_in = len_high_ff;
      flags_in    = flags_ff;
      command_in  = command_ff;
      crc_low_in  = crc_low_ff;
      res_valid   = 1'b0;
      res         = '0;
      if (fire) begin
         if (phase_ff == PHASE_HEAD) begin
            crc_in   = crc_next;
            count_in = count_ff + LEN_WIDTH'(1);
            case (count_ff[2:0])
               3'd0, 3'd1, 3'd2, 3'd3: begin
                  if (in_byte_ff != sync_byte(count_ff[1:0])) begin
                     sync_bad_in = 1'b1;
                  end
               end
               3'd4: begin
                  len_in = {9'b0, in_byte_ff};
               end
               3'd5: begin
                  len_in = len_ff | {1'b0, in_byte_ff, 8'b0};
               end
               3'd6: begin
                  len_in = len_ff | {in_byte_ff[0], 16'b0};
                  if (in_byte_ff[7:1] != 7'd0) begin
                     len_high_in = 1'b1;
                  end
               end
               default: begin
                  if (in_byte_ff != 8'd0) begin
                     len_high_in = 1'b1;
                  end
               end
            endcase
            if (count_ff[2:0] == 3'(HEAD_BYTES - 1)) begin
               if (sync_bad_in || len_high_in || len_in < MIN_PAYLOAD_LEN ||
                   len_in > max_len) begin
                  res_valid  = 1'b1;
                  res.kind   = KIND_STATUS;
                  res.status = sync_bad_in ? STATUS_BAD_SYNC : STATUS_BAD_LEN;
                  phase_in    = PHASE_HEAD;
                  count_in    = '0;
                  len_in      = '0;
                  crc_in      = CRC_INIT;
                  sync_bad_in = 1'b0;
                  len_high_in = 1'b0;
                  flags_in    = '0;
                  command_in  = '0;
                  crc_low_in  = '0;
               end else begin
                  phase_in = PHASE_PAYLOAD;
                  count_in = '0;
               end
            end
         end else begin
            if (idx_plus2 < len_wide) begin
               crc_in   = crc_next;
               count_in = count_ff + LEN_WIDTH'(1);
               if (count_ff == LEN_WIDTH'(0)) begin
                  flags_in = in_byte_ff;
               end else if (count_ff == LEN_WIDTH'(1)) begin
                  command_in = in_byte_ff;
               end else begin
                  res_valid       = 1'b1;
                  res.kind        = KIND_BODY;
                  res.body_byte   = in_byte_ff;
                  res.frame_flags = flags_ff;
                  res.command     = command_ff;
                  res.status      = STATUS_OK;
               end
            end else if (idx_plus2 == len_wide) begin
               crc_low_in = in_byte_ff;
               count_in   = count_ff + LEN_WIDTH'(1);
            end else begin
               res_valid       = 1'b1;
               res.kind        = KIND_STATUS;
               res.frame_flags = flags_ff;
               res.command     = command_ff;
               res.status      = ({in_byte_ff, crc_low_ff} == crc_ff) ? STATUS_OK
                                                                      : STATUS_BAD_CRC;
               phase_in    = PHASE_HEAD;
               count_in    = '0;
               len_in      = '0;
               crc_in      = CRC_INIT;
               sync_bad_in = 1'b0;
               len_high_in = 1'b0;
               flags_in    = '0;
               command_in  = '0;
               crc_low_in  = '0;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
         phase_ff    <= PHASE_HEAD;
         count_ff    <= '0;
         len_ff      <= '0;
         crc_ff      <= CRC_INIT;
         sync_bad_ff <= 1'b0;
         len_high_ff <= 1'b0;
         flags_ff    <= '0;
         command_ff  <= '0;
         crc_low_ff  <= '0;
      end else begin
         in_valid_ff <= in_valid_in;
         phase_ff    <= phase_in;
         count_ff    <= count_in;
         len_ff      <= len_in;
         crc_ff      <= crc_in;
         sync_bad_ff <= sync_bad_in;
         len_high_ff <= len_high_in;
         flags_ff    <= flags_in;
         command_ff  <= command_in;
         crc_low_ff  <= crc_low_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         in_byte_ff <= req_rx_byte;
      end
   end

endmodule

// ===== src/cfmr_out_buffer.sv =====
// Two-entry result register of the CRC framed message receiver, so that a single
// waiting result does not block the parser. Depends on cfmr_pkg.
module cfmr_out_buffer (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 push,
   input  cfmr_pkg::result_type push_data,
   output logic                 space,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output cfmr_pkg::result_type rsp_data
);
   import cfmr_pkg::*;

   result_type entry_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;
   logic       pop;

   assign space     = (count_ff != 2'd2);
   assign rsp_valid = (count_ff != 2'd0);
   assign rsp_data  = entry_ff[rd_ptr_ff];
   assign pop       = rsp_valid && !rsp_stall;

   always_comb begin
      wr_ptr_in = push ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? !rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + 2'(push) - 2'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

// ===== src/crc_framed_message_receiver.sv =====
// A request accepted into the parser's input register is parsed once the result
// buffer has space; its result, if any, is pushed there and offered on rsp_valid.
// Throughput: one request per cycle while the buffer has room, set by the
// byte-wide combinational CRC/frame step between input register and result buffer.
// Reset (synchronous, active high) empties both registers, returns the parser to
// head collection and loads the maximum payload length with 4096.
module crc_framed_message_receiver (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic [7:0]                    req_rx_byte,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic                          rsp_kind,
   output logic [7:0]                    rsp_body_byte,
   output logic [7:0]                    rsp_frame_flags,
   output logic [7:0]                    rsp_command,
   output logic [1:0]                    rsp_status,
   input  logic                          csr_write_enable,
   input  logic [cfmr_pkg::LEN_WIDTH-1:0] csr_write_data
);
   import cfmr_pkg::*;

   // The maximum payload length register. The user must write it only while the block is
   // idle (the block does not enforce this), so the parser may read it directly at the length check.
   logic [LEN_WIDTH-1:0] max_len_ff;

   // Between the parser and the result buffer: a result and its strobe, and
   // the buffer's report that it can take one more result.
   logic       res_valid;
   logic       res_space;
   result_type res;
   result_type rsp_data;

   always_ff @(posedge clock) begin
      if (reset) begin
         max_len_ff <= MAX_LEN_RESET;
      end else if (csr_write_enable) begin
         max_len_ff <= csr_write_data;
      end
   end

   // The parser registers each request, then runs the head check, length
   // check, CRC and body extraction on it combinationally.
   cfmr_parser u_parser (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_rx_byte (req_rx_byte),
      .max_len     (max_len_ff),
      .res_space   (res_space),
      .res_valid   (res_valid),
      .res         (res)
   );

   // The two-entry buffer keeps the parser running while one result waits
   // for the consumer; the parser stalls only when both entries are full.
   cfmr_out_buffer u_out_buffer (
      .clock     (clock),
      .reset     (reset),
      .push      (res_valid),
      .push_data (res),
      .space     (res_space),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   assign rsp_kind        = rsp_data.kind;
   assign rsp_body_byte   = rsp_data.body_byte;
   assign rsp_frame_flags = rsp_data.frame_flags;
   assign rsp_command     = rsp_data.command;
   assign rsp_status      = rsp_data.status;

endmodule
